// ===== rtl/core/cpv_pkg.sv =====
package cpv_pkg;

    localparam int MAX_DIM   = 8;
    localparam int FRAC_BITS = 48;
    localparam int SIZE_W    = 4;
    localparam int IDX_W     = SIZE_W + 1;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int NN_W      = 2 * SIZE_W + 1;

    localparam logic [63:0] ONE_Q      = 64'd1 << FRAC_BITS;
    localparam logic [63:0] NEG_ONE_Q  = ~ONE_Q + 64'd1;
    localparam logic [63:0] TOL_FACTOR = 64'd18446744074;
    localparam logic [63:0] INT_MAX    = {1'b0, {63{1'b1}}};
    localparam logic [63:0] INT_MIN    = {1'b1, 63'd0};

    localparam logic [SIZE_W-1:0] SIZE_RESET  = 4'd6;
    localparam logic [62:0]       LIMIT_RESET = 63'd28147497671065600;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_POLICY    = 3'd1,
        ST_UNAVAIL   = 3'd2,
        ST_NONFINITE = 3'd3,
        ST_DIAG      = 3'd4,
        ST_ASYM      = 3'd5,
        ST_NOT_PSD   = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        REG_SIZE   = 2'd0,
        REG_REJECT = 2'd1,
        REG_LIMIT  = 2'd2
    } t_reg;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } t_op;

    typedef enum logic [4:0] {
        E_IDLE, E_POLICY, E_DG_RD, E_DG_CK, E_TOL_GO, E_TOL_WT,
        E_SY_START, E_SY_RA, E_SY_RB, E_SY_CK,
        E_CH_ROW, E_CH_ACC, E_CH_P, E_CH_PX, E_CH_PY, E_CH_PM,
        E_CH_END, E_CH_SQ, E_CH_COL, E_CH_DV, E_FINISH
    } t_eng_state;

    typedef struct packed {
        logic [SIZE_W-1:0] n;
        logic              reject;
        logic              marker;
        logic              nonfinite;
        logic [62:0]       limit;
        logic [63:0]       largest;
    } t_job;

    typedef struct packed {
        logic        start;
        t_op         op;
        logic [63:0] a;
        logic [63:0] b;
    } t_arith_req;

    typedef struct packed {
        logic         done;
        logic [127:0] res;
    } t_arith_rsp;

    function automatic logic [63:0] magnitude(input logic [63:0] x);
        return x[63] ? (~x + 64'd1) : x;
    endfunction

    function automatic logic [63:0] signed_sat(input logic [63:0] m, input logic neg);
        logic [63:0] v;
        if (!neg) begin
            v = m[63] ? INT_MAX : m;
        end else begin
            v = m[63] ? INT_MIN : (~m + 64'd1);
        end
        return v;
    endfunction

    function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] d;
        logic [63:0] v;
        d = {a[63], a} - {b[63], b};
        if (d[64] != d[63]) begin
            v = d[64] ? INT_MIN : INT_MAX;
        end else begin
            v = d[63:0];
        end
        return v;
    endfunction

    function automatic logic [63:0] qmul_fix(input logic [127:0] p, input logic neg);
        logic [63:0] v;
        if (p[127:64+FRAC_BITS] != '0) begin
            v = signed_sat({64{1'b1}}, neg);
        end else begin
            v = signed_sat(p[63+FRAC_BITS:FRAC_BITS], neg);
        end
        return v;
    endfunction

    function automatic logic [63:0] qdiv_fix(input logic [127:0] q, input logic neg);
        logic [63:0] v;
        if (q[127:64] != 64'd0) begin
            v = signed_sat({64{1'b1}}, neg);
        end else begin
            v = signed_sat(q[63:0], neg);
        end
        return v;
    endfunction

    function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c,
                                                    input logic [SIZE_W-1:0] n);
        logic [2*IDX_W:0] t;
        t = (2*IDX_W+1)'(r) * (2*IDX_W+1)'(n) + (2*IDX_W+1)'(c);
        return t[ADDR_W-1:0];
    endfunction

endpackage

// ===== rtl/core/cpv_ram.sv =====
module cpv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/core/cpv_arith.sv =====
module cpv_arith (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cpv_pkg::t_arith_req i_req,
    output cpv_pkg::t_arith_rsp o_rsp
);
    import cpv_pkg::*;

    logic         r_busy;
    logic         r_done;
    t_op          r_op;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [6:0]   r_cnt;
    logic [127:0] r_acc;
    logic [63:0]  r_pp;
    logic [1:0]   r_pp_sh;
    logic         r_pp_vld;
    logic [127:0] r_dq;
    logic [67:0]  r_rem;
    logic [63:0]  r_root;

    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [127:0] pp_shifted;
    logic [64:0]  div_t;
    logic         div_ge;
    logic [67:0]  sq_t;
    logic [67:0]  sq_trial;
    logic         sq_ge;

    always_comb begin
        a_part = r_cnt[1] ? r_a[63:32] : r_a[31:0];
        b_part = r_cnt[0] ? r_b[63:32] : r_b[31:0];
        unique case (r_pp_sh)
            2'd0:    pp_shifted = {64'd0, r_pp};
            2'd1:    pp_shifted = {32'd0, r_pp, 32'd0};
            default: pp_shifted = {r_pp, 64'd0};
        endcase
        div_t    = {r_rem[63:0], r_dq[127]};
        div_ge   = div_t >= {1'b0, r_b};
        sq_t     = {r_rem[65:0], r_dq[127:126]};
        sq_trial = {2'd0, r_root, 2'b01};
        sq_ge    = sq_t >= sq_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
            r_pp_vld <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy   <= 1'b1;
                r_pp_vld <= 1'b0;
            end else if (r_busy) begin
                unique case (r_op)
                    OP_MUL: begin
                        r_pp_vld <= r_cnt < 7'd4;
                        if (r_cnt == 7'd4) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                    OP_DIV: begin
                        if (r_cnt == 7'd127) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                    OP_SQRT: begin
                        if (r_cnt == 7'd63) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                    default: r_busy <= 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op   <= i_req.op;
            r_a    <= i_req.a;
            r_b    <= i_req.b;
            r_cnt  <= 7'd0;
            r_acc  <= 128'd0;
            r_rem  <= 68'd0;
            r_root <= 64'd0;
            r_dq   <= {64'd0, i_req.a} << FRAC_BITS;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 7'd1;
            unique case (r_op)
                OP_MUL: begin
                    r_pp    <= 64'(a_part) * 64'(b_part);
                    r_pp_sh <= {r_cnt[1] & r_cnt[0], r_cnt[1] ^ r_cnt[0]};
                    if (r_pp_vld) begin
                        r_acc <= r_acc + pp_shifted;
                    end
                end
                OP_DIV: begin
                    r_rem <= div_ge ? 68'(div_t - {1'b0, r_b}) : 68'(div_t);
                    r_dq  <= {r_dq[126:0], div_ge};
                end
                OP_SQRT: begin
                    r_rem  <= sq_ge ? (sq_t - sq_trial) : sq_t;
                    r_root <= {r_root[62:0], sq_ge};
                    r_dq   <= {r_dq[125:0], 2'b00};
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        unique case (r_op)
            OP_MUL:  o_rsp.res = r_acc;
            OP_DIV:  o_rsp.res = r_dq;
            OP_SQRT: o_rsp.res = {64'd0, r_root};
            default: o_rsp.res = r_acc;
        endcase
    end

endmodule

// ===== rtl/core/cpv_engine.sv =====
module cpv_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  cpv_pkg::t_job               i_job,
    output logic [cpv_pkg::ADDR_W-1:0]  o_m_raddr,
    input  logic [63:0]                 i_m_rdata,
    output logic                        o_done,
    output cpv_pkg::t_status            o_status
);
    import cpv_pkg::*;

    t_eng_state  r_state, n_state;
    t_job        r_job;
    logic [IDX_W-1:0] r_r, n_r, r_c, n_c, r_p, n_p, r_t, n_t;
    logic        r_col, n_col, r_zero, n_zero;
    logic [63:0] r_acc, n_acc, r_x, n_x, r_y, n_y, r_tol, n_tol, r_piv, n_piv;
    logic [63:0] r_sa, n_sa;
    t_status     r_status, n_status;

    logic [ADDR_W-1:0] f_raddr, f_waddr;
    logic              f_we;
    logic [63:0]       f_wdata, f_rdata;
    t_arith_req        areq;
    t_arith_rsp        arsp;

    logic [IDX_W-1:0] nx;
    logic [64:0]      sdiff;
    logic [63:0]      dm;

    cpv_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_factor (
        .i_clk  (i_clk),
        .i_we   (f_we),
        .i_waddr(f_waddr),
        .i_wdata(f_wdata),
        .i_raddr(f_raddr),
        .o_rdata(f_rdata)
    );

    cpv_arith u_arith (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (areq),
        .o_rsp  (arsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_job <= i_job;
        end
        r_r      <= n_r;
        r_c      <= n_c;
        r_p      <= n_p;
        r_t      <= n_t;
        r_col    <= n_col;
        r_zero   <= n_zero;
        r_acc    <= n_acc;
        r_x      <= n_x;
        r_y      <= n_y;
        r_tol    <= n_tol;
        r_piv    <= n_piv;
        r_sa     <= n_sa;
        r_status <= n_status;
    end

    always_comb begin
        nx    = IDX_W'(r_job.n);
        sdiff = {r_sa[63], r_sa} - {i_m_rdata[63], i_m_rdata};
        dm    = sdiff[64] ? 64'(~sdiff + 65'd1) : sdiff[63:0];

        n_state  = r_state;
        n_r      = r_r;
        n_c      = r_c;
        n_p      = r_p;
        n_t      = r_t;
        n_col    = r_col;
        n_zero   = r_zero;
        n_acc    = r_acc;
        n_x      = r_x;
        n_y      = r_y;
        n_tol    = r_tol;
        n_piv    = r_piv;
        n_sa     = r_sa;
        n_status = r_status;

        o_m_raddr  = elem_addr(r_r, r_r, r_job.n);
        f_raddr    = elem_addr(r_t, r_p, r_job.n);
        f_we       = 1'b0;
        f_waddr    = elem_addr(r_c, r_r, r_job.n);
        f_wdata    = 64'd0;
        areq.start = 1'b0;
        areq.op    = OP_MUL;
        areq.a     = r_job.largest;
        areq.b     = TOL_FACTOR;
        o_done     = 1'b0;

        unique case (r_state)
            E_IDLE: begin
                if (i_go) begin
                    n_state = E_POLICY;
                end
            end
            E_POLICY: begin
                n_r = '0;
                priority if (r_job.limit == 63'd0) begin
                    n_status = ST_POLICY;
                    n_state  = E_FINISH;
                end else if (r_job.reject && r_job.marker) begin
                    n_status = ST_UNAVAIL;
                    n_state  = E_FINISH;
                end else if (r_job.nonfinite) begin
                    n_status = ST_NONFINITE;
                    n_state  = E_FINISH;
                end else begin
                    n_state = E_DG_RD;
                end
            end
            E_DG_RD: begin
                o_m_raddr = elem_addr(r_r, r_r, r_job.n);
                n_state   = E_DG_CK;
            end
            E_DG_CK: begin
                priority if (i_m_rdata[63] || (i_m_rdata[62:0] > r_job.limit)) begin
                    n_status = ST_DIAG;
                    n_state  = E_FINISH;
                end else if (r_r + IDX_W'(1) < nx) begin
                    n_r     = r_r + IDX_W'(1);
                    n_state = E_DG_RD;
                end else begin
                    n_state = E_TOL_GO;
                end
            end
            E_TOL_GO: begin
                areq.start = 1'b1;
                n_state    = E_TOL_WT;
            end
            E_TOL_WT: begin
                if (arsp.done) begin
                    n_tol   = arsp.res[127:64];
                    n_state = E_SY_START;
                end
            end
            E_SY_START: begin
                n_r = '0;
                n_c = IDX_W'(1);
                n_state = (nx < IDX_W'(2)) ? E_CH_ROW : E_SY_RA;
            end
            E_SY_RA: begin
                o_m_raddr = elem_addr(r_r, r_c, r_job.n);
                n_state   = E_SY_RB;
            end
            E_SY_RB: begin
                n_sa      = i_m_rdata;
                o_m_raddr = elem_addr(r_c, r_r, r_job.n);
                n_state   = E_SY_CK;
            end
            E_SY_CK: begin
                priority if (dm > r_tol) begin
                    n_status = ST_ASYM;
                    n_state  = E_FINISH;
                end else if (r_c + IDX_W'(1) < nx) begin
                    n_c     = r_c + IDX_W'(1);
                    n_state = E_SY_RA;
                end else if (r_r + IDX_W'(2) < nx) begin
                    n_r     = r_r + IDX_W'(1);
                    n_c     = r_r + IDX_W'(2);
                    n_state = E_SY_RA;
                end else begin
                    n_r     = '0;
                    n_state = E_CH_ROW;
                end
            end
            E_CH_ROW: begin
                o_m_raddr = elem_addr(r_r, r_r, r_job.n);
                n_t       = r_r;
                n_col     = 1'b0;
                n_state   = E_CH_ACC;
            end
            E_CH_ACC: begin
                n_acc   = i_m_rdata;
                n_p     = '0;
                n_state = E_CH_P;
            end
            E_CH_P: begin
                f_raddr = elem_addr(r_t, r_p, r_job.n);
                n_state = (r_p == r_r) ? E_CH_END : E_CH_PX;
            end
            E_CH_PX: begin
                n_x     = f_rdata;
                f_raddr = elem_addr(r_r, r_p, r_job.n);
                n_state = E_CH_PY;
            end
            E_CH_PY: begin
                n_y        = f_rdata;
                areq.start = 1'b1;
                areq.op    = OP_MUL;
                areq.a     = magnitude(r_x);
                areq.b     = magnitude(f_rdata);
                n_state    = E_CH_PM;
            end
            E_CH_PM: begin
                if (arsp.done) begin
                    n_acc   = sat_sub(r_acc, qmul_fix(arsp.res, r_x[63] ^ r_y[63]));
                    n_p     = r_p + IDX_W'(1);
                    n_state = E_CH_P;
                end
            end
            E_CH_END: begin
                if (!r_col) begin
                    priority if ($signed(r_acc) < -$signed(r_tol)) begin
                        n_status = ST_NOT_PSD;
                        n_state  = E_FINISH;
                    end else if ($signed(r_acc) <= $signed(r_tol)) begin
                        n_zero  = 1'b1;
                        n_c     = r_r + IDX_W'(1);
                        n_state = E_CH_COL;
                    end else begin
                        n_zero     = 1'b0;
                        areq.start = 1'b1;
                        areq.op    = OP_SQRT;
                        areq.a     = r_acc;
                        n_state    = E_CH_SQ;
                    end
                end else if (r_zero) begin
                    if (magnitude(r_acc) > r_tol) begin
                        n_status = ST_NOT_PSD;
                        n_state  = E_FINISH;
                    end else begin
                        f_we    = 1'b1;
                        f_waddr = elem_addr(r_c, r_r, r_job.n);
                        f_wdata = 64'd0;
                        n_c     = r_c + IDX_W'(1);
                        n_state = E_CH_COL;
                    end
                end else begin
                    areq.start = 1'b1;
                    areq.op    = OP_DIV;
                    areq.a     = magnitude(r_acc);
                    areq.b     = r_piv;
                    n_state    = E_CH_DV;
                end
            end
            E_CH_SQ: begin
                if (arsp.done) begin
                    n_piv   = arsp.res[63:0];
                    f_we    = 1'b1;
                    f_waddr = elem_addr(r_r, r_r, r_job.n);
                    f_wdata = arsp.res[63:0];
                    n_c     = r_r + IDX_W'(1);
                    n_state = E_CH_COL;
                end
            end
            E_CH_COL: begin
                priority if (r_c < nx) begin
                    o_m_raddr = elem_addr(r_c, r_r, r_job.n);
                    n_t       = r_c;
                    n_col     = 1'b1;
                    n_state   = E_CH_ACC;
                end else if (r_r + IDX_W'(1) < nx) begin
                    n_r     = r_r + IDX_W'(1);
                    n_state = E_CH_ROW;
                end else begin
                    n_status = ST_OK;
                    n_state  = E_FINISH;
                end
            end
            E_CH_DV: begin
                if (arsp.done) begin
                    f_we    = 1'b1;
                    f_waddr = elem_addr(r_c, r_r, r_job.n);
                    f_wdata = qdiv_fix(arsp.res, r_acc[63]);
                    n_c     = r_c + IDX_W'(1);
                    n_state = E_CH_COL;
                end
            end
            E_FINISH: begin
                o_done  = 1'b1;
                n_state = E_IDLE;
            end
            default: n_state = E_IDLE;
        endcase
    end

    assign o_status = r_status;

endmodule

// ===== rtl/core/covariance_psd_validator.sv =====
// Channel   Handshake                         Payload
// ------    --------------------------------  ----------------------------------------
// input     start && !busy                    i_element_value, i_element_nonfinite
// result    o_done (one cycle, no stall)      o_accepted, o_status
// config    psel && penable && pwrite         paddr (8-byte regs), pwdata, prdata
//
// An element that does not complete the matrix is taken without raising busy; a bad size answers
// in the next cycle. The last element starts the verdict, which holds busy high
// while the diagonal and symmetry checks, product terms, square roots and divides
// run in turn on one shared iterative arithmetic unit.
// Reset is synchronous and restores the register defaults and an empty load.
// Results cannot be stalled; a new transaction may be accepted while o_done is high.
module covariance_psd_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_element_value,
    input  logic        i_element_nonfinite,
    output logic        o_done,
    output logic        o_accepted,
    output logic [2:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import cpv_pkg::*;

    logic [SIZE_W-1:0] r_size;
    logic              r_reject;
    logic [62:0]       r_limit;
    logic [CNT_W-1:0]  r_count;
    logic              r_nonfinite;
    logic              r_marker;
    logic [63:0]       r_largest;
    logic              r_busy;
    logic              r_go;
    logic              r_done;
    t_status           r_status;

    logic              accept;
    logic              wr;
    t_reg              widx;
    logic              bad_size;
    logic [NN_W-1:0]   nn;
    logic              last;
    logic [63:0]       vmag;
    t_job              job;
    logic [ADDR_W-1:0] m_raddr;
    logic [63:0]       m_rdata;
    logic              eng_done;
    t_status           eng_status;

    assign accept   = start && !r_busy;
    assign wr       = psel && penable && pwrite;
    assign widx     = t_reg'(paddr[4:3]);
    assign bad_size = (r_size == '0) || (32'(r_size) > MAX_DIM);
    assign nn       = NN_W'(r_size) * NN_W'(r_size);
    assign last     = (NN_W'(r_count) + NN_W'(1)) == nn;
    assign vmag     = magnitude(i_element_value);

    always_comb begin
        job.n         = r_size;
        job.reject    = r_reject;
        job.marker    = r_marker;
        job.nonfinite = r_nonfinite;
        job.limit     = r_limit;
        job.largest   = r_largest;
    end

    cpv_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_matrix (
        .i_clk  (i_clk),
        .i_we   (accept && !bad_size),
        .i_waddr(r_count[ADDR_W-1:0]),
        .i_wdata(i_element_value),
        .i_raddr(m_raddr),
        .o_rdata(m_rdata)
    );

    cpv_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (r_go),
        .i_job    (job),
        .o_m_raddr(m_raddr),
        .i_m_rdata(m_rdata),
        .o_done   (eng_done),
        .o_status (eng_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= SIZE_RESET;
            r_reject    <= 1'b1;
            r_limit     <= LIMIT_RESET;
            r_count     <= '0;
            r_nonfinite <= 1'b0;
            r_marker    <= 1'b0;
            r_largest   <= ONE_Q;
            r_busy      <= 1'b0;
            r_go        <= 1'b0;
            r_done      <= 1'b0;
            r_status    <= ST_OK;
        end else begin
            r_done <= 1'b0;
            r_go   <= 1'b0;
            if (wr) begin
                unique case (widx)
                    REG_SIZE: begin
                        r_size      <= pwdata[SIZE_W-1:0];
                        r_count     <= '0;
                        r_nonfinite <= 1'b0;
                        r_marker    <= 1'b0;
                        r_largest   <= ONE_Q;
                    end
                    REG_REJECT: r_reject <= pwdata[0];
                    REG_LIMIT:  r_limit  <= pwdata[62:0];
                    default: ;
                endcase
            end
            if (eng_done) begin
                r_done      <= 1'b1;
                r_status    <= eng_status;
                r_busy      <= 1'b0;
                r_count     <= '0;
                r_nonfinite <= 1'b0;
                r_marker    <= 1'b0;
                r_largest   <= ONE_Q;
            end else if (accept) begin
                if (bad_size) begin
                    r_done      <= 1'b1;
                    r_status    <= ST_POLICY;
                    r_count     <= '0;
                    r_nonfinite <= 1'b0;
                    r_marker    <= 1'b0;
                    r_largest   <= ONE_Q;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                    if (r_count == '0 && !i_element_nonfinite
                        && i_element_value == NEG_ONE_Q) begin
                        r_marker <= 1'b1;
                    end
                    if (i_element_nonfinite) begin
                        r_nonfinite <= 1'b1;
                    end else if (vmag > r_largest) begin
                        r_largest <= vmag;
                    end
                    if (last) begin
                        r_busy <= 1'b1;
                        r_go   <= 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        unique case (widx)
            REG_SIZE:   prdata = 64'(r_size);
            REG_REJECT: prdata = 64'(r_reject);
            REG_LIMIT:  prdata = {1'b0, r_limit};
            default:    prdata = 64'd0;
        endcase
    end

    assign pready     = 1'b1;
    assign busy       = r_busy;
    assign o_done     = r_done;
    assign o_accepted = (r_status == ST_OK);
    assign o_status   = r_status;

endmodule
